/* rtl/escape_sequence_decoder_top_defines.svh */
// Assertion macros shared by the decoder modules.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/esd_pkg.sv */
`timescale 1ns / 1ps

package esd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_OCTAL  = 3'b100
	} mode_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_of_string;
	} result_t;

	typedef struct packed {
		result_t [1:0] res;
		logic [1:0]    cnt;
	} step_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_APOS      = 8'h27;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_V   = 8'h76;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;

	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_VT  = 8'h0B;

	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

endpackage

/* rtl/esd_in_if.sv */
`timescale 1ns / 1ps

interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       last;

	modport source (output valid, output in_char, output last, input ready);
	modport sink (input valid, input in_char, input last, output ready);
endinterface

/* rtl/esd_out_if.sv */
`timescale 1ns / 1ps

interface esd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       end_of_string;

	modport source (output valid, output out_char, output char_valid, output end_of_string,
		input ready);
	modport sink (input valid, input out_char, input char_valid, input end_of_string,
		output ready);
endinterface

/* rtl/escape_sequence_decoder_top.sv */
`timescale 1ns / 1ps
// An accepted item goes through the input register and the parser into the result register.
// Throughput: one item per cycle while the output is ready; an item that yields two requests
// holds the result register until both are taken, and the input stalls until the second is taken.
// Reset: arst_n clears the parse state, the input stage and the pending requests at once.

module escape_sequence_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	esd_in_if.sink     in_ch,
	esd_out_if.source  out_ch
);

	logic           v_s1;
	logic [7:0]     char_s1;
	logic           last_s1;
	logic           free;
	logic           step;
	esd_pkg::step_t result;

	assign step        = v_s1 && free;
	assign in_ch.ready = !v_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.in_char;
			last_s1 <= in_ch.last;
		end
	end

	esd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_char (char_s1),
		.last    (last_s1),
		.result  (result)
	);

	esd_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s1),
		.result     (result),
		.free       (free),
		.out_ch     (out_ch)
	);

endmodule

/* rtl/esd_parser.sv */
`timescale 1ns / 1ps
`include "escape_sequence_decoder_top_defines.svh"

module esd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     in_char,
	input  logic           last,
	output esd_pkg::step_t result
);

	esd_pkg::mode_t mode_q;
	logic [8:0]     oval_q;
	logic [1:0]     odig_q;

	esd_pkg::mode_t mode_d;
	logic [8:0]     oval_d;
	logic [1:0]     odig_d;

	function automatic esd_pkg::step_t push(input esd_pkg::step_t s, input logic [7:0] ch,
		input logic vld);
		esd_pkg::step_t r;
		r = s;
		r.res[s.cnt[0]].out_char = ch;
		r.res[s.cnt[0]].char_valid = vld;
		r.res[s.cnt[0]].end_of_string = 1'b0;
		r.cnt = s.cnt + 2'd1;
		return r;
	endfunction

	always_comb begin
		esd_pkg::step_t st;
		logic           is_oct;
		logic [2:0]     digit;
		logic [8:0]     acc;
		logic [1:0]     dig_next;

		st = '0;
		mode_d = mode_q;
		oval_d = oval_q;
		odig_d = odig_q;
		is_oct = in_char inside {[esd_pkg::CH_ZERO:esd_pkg::CH_SEVEN]};
		digit = in_char[2:0];
		acc = {oval_q[5:0], digit};
		dig_next = odig_q + 2'd1;

		case (mode_q)
			esd_pkg::MODE_ESCAPE: begin
				mode_d = esd_pkg::MODE_NORMAL;
				if (in_char == esd_pkg::CH_NEWLINE) begin
					mode_d = esd_pkg::MODE_NORMAL;
				end else if (is_oct) begin
					mode_d = esd_pkg::MODE_OCTAL;
					oval_d = {6'd0, digit};
					odig_d = 2'd1;
				end else if (in_char == esd_pkg::CH_LOWER_N) begin
					st = push(st, esd_pkg::CODE_LF, 1'b1);
				end else if (in_char == esd_pkg::CH_LOWER_R) begin
					st = push(st, esd_pkg::CODE_CR, 1'b1);
				end else if (in_char == esd_pkg::CH_LOWER_T) begin
					st = push(st, esd_pkg::CODE_TAB, 1'b1);
				end else if (in_char == esd_pkg::CH_LOWER_V) begin
					st = push(st, esd_pkg::CODE_VT, 1'b1);
				end else begin
					// Quotes, backslash and unknown escapes all yield the character itself.
					st = push(st, in_char, 1'b1);
				end
			end
			esd_pkg::MODE_OCTAL: begin
				if (is_oct && odig_q < esd_pkg::OCT_MAX_DIGITS) begin
					if (dig_next >= esd_pkg::OCT_MAX_DIGITS) begin
						if (!acc[8]) begin
							st = push(st, acc[7:0], 1'b1);
						end
						mode_d = esd_pkg::MODE_NORMAL;
						oval_d = '0;
						odig_d = '0;
					end else begin
						oval_d = acc;
						odig_d = dig_next;
					end
				end else begin
					if (!oval_q[8]) begin
						st = push(st, oval_q[7:0], 1'b1);
					end
					oval_d = '0;
					odig_d = '0;
					if (in_char == esd_pkg::CH_BACKSLASH) begin
						mode_d = esd_pkg::MODE_ESCAPE;
					end else begin
						mode_d = esd_pkg::MODE_NORMAL;
						st = push(st, in_char, 1'b1);
					end
				end
			end
			default: begin
				if (in_char == esd_pkg::CH_BACKSLASH) begin
					mode_d = esd_pkg::MODE_ESCAPE;
				end else begin
					mode_d = esd_pkg::MODE_NORMAL;
					st = push(st, in_char, 1'b1);
				end
			end
		endcase

		if (last) begin
			if (mode_d == esd_pkg::MODE_OCTAL && !oval_d[8]) begin
				st = push(st, oval_d[7:0], 1'b1);
			end
			mode_d = esd_pkg::MODE_NORMAL;
			oval_d = '0;
			odig_d = '0;
			if (st.cnt == 2'd0) begin
				st = push(st, 8'd0, 1'b0);
			end
			st.res[st.cnt == 2'd2].end_of_string = 1'b1;
		end

		result = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esd_pkg::MODE_NORMAL;
			oval_q <= '0;
			odig_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			oval_q <= oval_d;
			odig_q <= odig_d;
		end
	end

	`ESD_ASSERT_NEXT(a_last_resets, clk, arst_n, step && last,
		mode_q == esd_pkg::MODE_NORMAL && odig_q == 2'd0 && oval_q == 9'd0,
		"State not cleared after the last character.")
	`ESD_ASSERT_NOW(a_octal_digits, clk, arst_n, mode_q == esd_pkg::MODE_OCTAL,
		odig_q == 2'd1 || odig_q == 2'd2, "Open octal run holds a bad digit count.")
	`ESD_ASSERT_NOW(a_idle_octal_clear, clk, arst_n, mode_q != esd_pkg::MODE_OCTAL,
		odig_q == 2'd0 && oval_q == 9'd0, "Octal value left over outside an octal run.")

endmodule

/* rtl/esd_outbuf.sv */
`timescale 1ns / 1ps
`include "escape_sequence_decoder_top_defines.svh"

module esd_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  esd_pkg::step_t   result,
	output logic             free,
	esd_out_if.source        out_ch
);

	esd_pkg::result_t r0_q;
	esd_pkg::result_t r1_q;
	logic [1:0]       rem_q;
	logic             load;
	logic             pop;

	assign free = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ch.ready);
	assign load = item_valid && free;
	assign pop  = (rem_q != 2'd0) && out_ch.ready;

	assign out_ch.valid         = rem_q != 2'd0;
	assign out_ch.out_char      = r0_q.out_char;
	assign out_ch.char_valid    = r0_q.char_valid;
	assign out_ch.end_of_string = r0_q.end_of_string;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= result.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= result.res[0];
			r1_q <= result.res[1];
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

	`ESD_ASSERT_NEXT(a_pop_second, clk, arst_n, rem_q == 2'd2 && out_ch.ready,
		rem_q == 2'd1, "Second pending request not moved forward.")
	`ESD_ASSERT_NEXT(a_hold_pair, clk, arst_n, rem_q == 2'd2 && !out_ch.ready,
		rem_q == 2'd2, "Pending pair changed while stalled.")
	`ESD_ASSERT_NEXT(a_load_count, clk, arst_n, load, rem_q == $past(result.cnt),
		"Pending count does not match the decoded item.")

endmodule
